// File: hw/rtl/spf_pkg.sv
// Shared types and constants for the smallest prime factor sieve.
`timescale 1ns / 1ps
package spf_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_ONE = 2'd1,
		ST_OOR = 2'd2
	} status_t;

	localparam int unsigned EXP_W   = 5;
	localparam int unsigned RUN_W   = 3;
	localparam logic [RUN_W-1:0] MAX_RUN = 3'd6;

endpackage

// File: hw/rtl/smallest_prime_factor_sieve.sv
// Smallest prime factor table with sieve build and per-query factorization.
// Build: the first query after reset or a limit write first clears entries 2..limit
//   and then runs the sieve.
// Factorization: each prime factor occurrence is divided out by the bit-serial divider.
// One item in flight at a time; out-of-range and one answers pass through the CHECK and FIN states after accept.
// Reset: asynchronous, limit returns to MAX_LIMIT and the table is marked unbuilt.
`timescale 1ns / 1ps
module smallest_prime_factor_sieve
	import spf_pkg::*;
#(
	parameter int unsigned MAX_LIMIT = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 limit_we,
	input  logic [$clog2(MAX_LIMIT+1)-1:0]       limit_wdata,
	input  logic                                 query_valid,
	output logic                                 query_ready,
	input  logic [$clog2(MAX_LIMIT+1)-1:0]       query_value,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [$clog2(MAX_LIMIT+1)-1:0]       prime,
	output logic [EXP_W-1:0]                     exponent,
	output logic                                 is_prime,
	output logic [1:0]                           status,
	output logic                                 last
);

	localparam int unsigned VW = $clog2(MAX_LIMIT + 1);
	localparam logic [VW-1:0] MAXV = VW'(MAX_LIMIT);
	localparam logic [VW-1:0] TWO  = VW'(2);
	localparam logic [VW-1:0] ONE  = VW'(1);

	typedef enum logic [3:0] {
		IDLE, CLR, S_RD, S_CHK, S_SQ, S_NEXT, M_RD, M_CHK,
		CHECK, F_RD, F_CHK, F_DEC, DIV, FIN
	} state_t;

	state_t          state_q;
	logic [VW-1:0]   limit_q;
	logic            built_q;
	logic [VW-1:0]   q_q;
	logic [VW-1:0]   i_q;
	logic [VW:0]     j_q;
	logic [2*VW-1:0] sq_s1;
	logic [VW-1:0]   x_q;
	logic [VW-1:0]   p_q;
	logic [VW-1:0]   cur_p_q;
	logic [EXP_W-1:0] cur_e_q;
	logic [RUN_W-1:0] n_q;
	logic            ip_q;
	status_t         st_q;
	logic            div_start_q;

	logic            rv_q;
	logic [VW-1:0]   prime_q;
	logic [EXP_W-1:0] exp_q;
	logic            ip_out_q;
	status_t         st_out_q;
	logic            last_q;

	logic            mem_we;
	logic [VW-1:0]   mem_waddr;
	logic [VW-1:0]   mem_wdata;
	logic [VW-1:0]   mem_raddr;
	logic [VW-1:0]   mem_rdata;
	logic            div_done;
	logic [VW-1:0]   div_quo;
	logic [VW:0]     jn;
	logic            out_free;

	spf_mem #(.DEPTH(MAX_LIMIT + 1), .AW(VW), .DW(VW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	spf_div #(.W(VW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (x_q),
		.den    (p_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign jn       = j_q + (VW+1)'(i_q);
	assign out_free = !rv_q || result_ready;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = '0;
		mem_raddr = i_q;
		unique case (state_q)
			CLR: begin
				mem_we = 1'b1;
			end
			S_CHK: begin
				mem_we    = (mem_rdata == '0);
				mem_wdata = i_q;
			end
			M_CHK: begin
				mem_we    = (mem_rdata == '0);
				mem_waddr = j_q[VW-1:0];
				mem_wdata = i_q;
			end
			M_RD: mem_raddr = j_q[VW-1:0];
			F_RD: mem_raddr = x_q;
			default: ;
		endcase
	end

	// control FSM and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			limit_q     <= MAXV;
			built_q     <= 1'b0;
			rv_q        <= 1'b0;
			div_start_q <= 1'b0;
			n_q         <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (rv_q && result_ready) begin
				rv_q <= 1'b0;
			end
			if (limit_we) begin
				built_q <= 1'b0;
				if (limit_wdata < TWO) begin
					limit_q <= TWO;
				end else if (limit_wdata > MAXV) begin
					limit_q <= MAXV;
				end else begin
					limit_q <= limit_wdata;
				end
			end
			unique case (state_q)
				IDLE: begin
					if (query_valid) begin
						q_q <= query_value;
						if (built_q) begin
							state_q <= CHECK;
						end else begin
							i_q     <= TWO;
							state_q <= CLR;
						end
					end
				end
				CLR: begin
					if (i_q == limit_q) begin
						i_q     <= TWO;
						state_q <= S_RD;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (mem_rdata == '0) begin
						sq_s1   <= (2*VW)'(i_q) * (2*VW)'(i_q);
						state_q <= S_SQ;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_SQ: begin
					if (sq_s1 <= (2*VW)'(limit_q)) begin
						j_q     <= sq_s1[VW:0];
						state_q <= M_RD;
					end else begin
						state_q <= S_NEXT;
					end
				end
				M_RD: state_q <= M_CHK;
				M_CHK: begin
					if (jn <= (VW+1)'(limit_q)) begin
						j_q     <= jn;
						state_q <= M_RD;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (i_q == limit_q) begin
						built_q <= 1'b1;
						state_q <= CHECK;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RD;
					end
				end
				CHECK: begin
					cur_p_q <= '0;
					cur_e_q <= '0;
					ip_q    <= 1'b0;
					n_q     <= '0;
					x_q     <= q_q;
					if (q_q == '0 || q_q > limit_q) begin
						st_q    <= ST_OOR;
						state_q <= FIN;
					end else if (q_q == ONE) begin
						st_q    <= ST_ONE;
						state_q <= FIN;
					end else begin
						st_q    <= ST_OK;
						state_q <= F_RD;
					end
				end
				F_RD: state_q <= F_CHK;
				F_CHK: begin
					p_q <= mem_rdata;
					if (x_q == q_q) begin
						ip_q <= (mem_rdata == q_q);
					end
					state_q <= F_DEC;
				end
				F_DEC: begin
					if (p_q < TWO) begin
						state_q <= FIN;
					end else if (n_q != '0 && p_q == cur_p_q) begin
						cur_e_q     <= cur_e_q + 1'b1;
						div_start_q <= 1'b1;
						state_q     <= DIV;
					end else if (n_q == MAX_RUN) begin
						state_q <= FIN;
					end else if (n_q == '0 || out_free) begin
						// flush the finished prime before starting a new one
						if (n_q != '0) begin
							rv_q     <= 1'b1;
							prime_q  <= cur_p_q;
							exp_q    <= cur_e_q;
							ip_out_q <= ip_q;
							st_out_q <= ST_OK;
							last_q   <= 1'b0;
						end
						cur_p_q     <= p_q;
						cur_e_q     <= EXP_W'(1);
						n_q         <= n_q + 1'b1;
						div_start_q <= 1'b1;
						state_q     <= DIV;
					end
				end
				DIV: begin
					if (div_done) begin
						x_q     <= div_quo;
						state_q <= (div_quo == ONE) ? FIN : F_RD;
					end
				end
				FIN: begin
					if (out_free) begin
						rv_q     <= 1'b1;
						prime_q  <= cur_p_q;
						exp_q    <= cur_e_q;
						ip_out_q <= ip_q;
						st_out_q <= st_q;
						last_q   <= 1'b1;
						state_q  <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign query_ready  = (state_q == IDLE);
	assign result_valid = rv_q;
	assign prime        = prime_q;
	assign exponent     = exp_q;
	assign is_prime     = ip_out_q;
	assign status       = st_out_q;
	assign last         = last_q;

	// no table writes while waiting for a query
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == IDLE |-> !mem_we)
		else $error("table written while idle");

	// an unbuilt table is always cleared first
	a_build_first: assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && query_ready && !built_q |=> state_q == CLR)
		else $error("query answered before table build");

	// run count never passes the cap
	a_run_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= MAX_RUN)
		else $error("run count over cap");

	// divider finishes only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == DIV)
		else $error("unexpected divider completion");

endmodule

// File: hw/rtl/spf_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
`timescale 1ns / 1ps
module spf_mem #(
	parameter int unsigned DEPTH = 65537,
	parameter int unsigned AW    = 17,
	parameter int unsigned DW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/spf_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module spf_div #(
	parameter int unsigned W = 17
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo
);

	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	// shift in next numerator bit and try a subtract
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
